// File: design/ltt_pkg.sv
// ----------------------------------------------------------------------------
// ltt_pkg: shared types and constants of the l-system turtle
// widths, opcodes, register indexes, status codes and the queued item format
// ----------------------------------------------------------------------------
package ltt_pkg;

  // branch stack size
  localparam int STACK_DEPTH = 32;
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_LW      = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int POS_W      = 32;
  localparam int DIR_W      = 16;
  localparam int STEP_W     = 31;
  localparam int TRIG_W     = 16;
  localparam int OP_W       = 4;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int STK_W      = 3 * POS_W + 3 * DIR_W;

  // fixed-point rounding of q2.14 products
  localparam int FRAC_DIR = 14;
  localparam int HALF_LSB = 1 << (FRAC_DIR - 1);

  // decoupling queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // symbol opcodes
  localparam logic [OP_W-1:0] OP_FWD_DRAW  = 4'd0;
  localparam logic [OP_W-1:0] OP_FWD_MOVE  = 4'd1;
  localparam logic [OP_W-1:0] OP_TURN_POS  = 4'd2;
  localparam logic [OP_W-1:0] OP_TURN_NEG  = 4'd3;
  localparam logic [OP_W-1:0] OP_PITCH_POS = 4'd4;
  localparam logic [OP_W-1:0] OP_PITCH_NEG = 4'd5;
  localparam logic [OP_W-1:0] OP_ROLL_POS  = 4'd6;
  localparam logic [OP_W-1:0] OP_ROLL_NEG  = 4'd7;
  localparam logic [OP_W-1:0] OP_REVERSE   = 4'd8;
  localparam logic [OP_W-1:0] OP_PUSH      = 4'd9;
  localparam logic [OP_W-1:0] OP_POP       = 4'd10;
  localparam logic [OP_W-1:0] OP_BEGIN     = 4'd11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_COS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_SIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Z_COS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SIN = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] ST_POINT = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

  // reset values
  localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;
  localparam logic [TRIG_W-1:0] TRIG_ONE   = 16'd16384;

  // decoded command classes
  typedef enum logic [2:0] {
    K_NOP,
    K_MOVE,
    K_ROT,
    K_REV,
    K_PUSH,
    K_POP,
    K_BEGIN
  } kind_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef struct packed {
    kind_t kind;
    logic  pen;
    logic  neg;
    axis_t axis;
  } cmd_t;

  // one queued item
  typedef struct packed {
    cmd_t                    cmd;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] sz;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dz;
  } item_t;

endpackage

// File: design/ltt_ram.sv
// ----------------------------------------------------------------------------
// ltt_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ltt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/ltt_front.sv
// ----------------------------------------------------------------------------
// ltt_front: input side of the turtle
// accepts items, decodes the symbol into a command and queues it for the back
// ----------------------------------------------------------------------------
module ltt_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ltt_pkg::OP_W-1:0]            opcode,
  input  logic signed [ltt_pkg::POS_W-1:0]    start_pos_x,
  input  logic signed [ltt_pkg::POS_W-1:0]    start_pos_y,
  input  logic signed [ltt_pkg::POS_W-1:0]    start_pos_z,
  input  logic signed [ltt_pkg::DIR_W-1:0]    start_dir_x,
  input  logic signed [ltt_pkg::DIR_W-1:0]    start_dir_y,
  input  logic signed [ltt_pkg::DIR_W-1:0]    start_dir_z,
  output logic                                q_valid,
  output ltt_pkg::item_t                      q_item,
  input  logic                                q_pop
);
  import ltt_pkg::*;

  item_t           q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            accept;
  logic            pop_ok;

  // symbol decode
  function automatic cmd_t decode(input logic [OP_W-1:0] op);
    cmd_t c;
    c.kind = K_NOP;
    c.pen  = 1'b0;
    c.neg  = 1'b0;
    c.axis = AX_X;
    unique case (op)
      OP_FWD_DRAW: begin
        c.kind = K_MOVE;
        c.pen  = 1'b1;
      end
      OP_FWD_MOVE:  c.kind = K_MOVE;
      OP_TURN_POS:  c.kind = K_ROT;
      OP_TURN_NEG: begin
        c.kind = K_ROT;
        c.neg  = 1'b1;
      end
      OP_PITCH_POS: begin
        c.kind = K_ROT;
        c.axis = AX_Y;
      end
      OP_PITCH_NEG: begin
        c.kind = K_ROT;
        c.axis = AX_Y;
        c.neg  = 1'b1;
      end
      OP_ROLL_POS: begin
        c.kind = K_ROT;
        c.axis = AX_Z;
      end
      OP_ROLL_NEG: begin
        c.kind = K_ROT;
        c.axis = AX_Z;
        c.neg  = 1'b1;
      end
      OP_REVERSE: c.kind = K_REV;
      OP_PUSH:    c.kind = K_PUSH;
      OP_POP:     c.kind = K_POP;
      OP_BEGIN:   c.kind = K_BEGIN;
      default:    c.kind = K_NOP;
    endcase
    return c;
  endfunction

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
  endfunction

  // handshake
  assign in_stall = (count == Q_CW'(Q_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop_ok   = q_pop && q_valid;
  assign q_item   = q_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr] <= '{cmd: decode(opcode),
                         sx: start_pos_x, sy: start_pos_y, sz: start_pos_z,
                         dx: start_dir_x, dy: start_dir_y, dz: start_dir_z};
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop_ok) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({accept, pop_ok})
        2'b10:   count <= count + Q_CW'(1);
        2'b01:   count <= count - Q_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/ltt_back.sv
// ----------------------------------------------------------------------------
// ltt_back: execution side of the turtle
// holds turtle state, config registers and branch stack, and drives results
// ----------------------------------------------------------------------------
module ltt_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ltt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ltt_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_valid,
  input  ltt_pkg::item_t                      q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ltt_pkg::POS_W-1:0]    pos_x,
  output logic signed [ltt_pkg::POS_W-1:0]    pos_y,
  output logic signed [ltt_pkg::POS_W-1:0]    pos_z,
  output logic                                pen_down,
  output logic                                last_of_run,
  output logic [ltt_pkg::STAT_W-1:0]          status
);
  import ltt_pkg::*;

  localparam int MP_W  = DIR_W + STEP_W + 1;   // move product
  localparam int MS_W  = POS_W + 3;            // move sum before saturation
  localparam int RP_W  = TRIG_W + DIR_W + 1;   // rotation product
  localparam int RS_W  = RP_W + 1;             // rotation sum
  localparam int RR_W  = RS_W - FRAC_DIR;      // rounded rotation sum

  // configuration
  logic [STEP_W-1:0]        step_len;
  logic signed [TRIG_W-1:0] rot_x_cos, rot_x_sin;
  logic signed [TRIG_W-1:0] rot_y_cos, rot_y_sin;
  logic signed [TRIG_W-1:0] rot_z_cos, rot_z_sin;

  // turtle state
  logic signed [POS_W-1:0] tpos_x, tpos_y, tpos_z;
  logic signed [DIR_W-1:0] tdir_x, tdir_y, tdir_z;
  logic [STK_LW-1:0]       stk_level;
  logic [STK_LW-1:0]       stk_level_dec;
  logic                    phase;

  // product registers
  logic signed [MP_W-1:0]  mp_x, mp_y, mp_z;
  logic signed [RP_W-1:0]  rp_ca, rp_sb, rp_sa, rp_cb;

  // stack ram
  logic [STK_W-1:0] stk_rdata;
  logic [STK_W-1:0] stk_wdata;

  cmd_t cmd;
  logic can_emit, stk_full, stk_empty;
  logic act_move0, act_move1, act_rot0, act_rot1, act_rev, act_push, act_over;
  logic act_pop0, act_pop1, act_under, act_begin, act_nop, emit;

  logic signed [DIR_W-1:0]  rot_a, rot_b;
  logic signed [TRIG_W-1:0] rot_c, rot_s;
  logic signed [TRIG_W:0]   c_ext, s_eff;
  logic signed [DIR_W-1:0]  rot_na, rot_nb;
  logic signed [POS_W-1:0]  nxt_x, nxt_y, nxt_z;

  // position step with round and saturation
  function automatic logic signed [POS_W-1:0] move_comp(
    input logic signed [POS_W-1:0] p,
    input logic signed [MP_W-1:0]  prod
  );
    logic [MP_W-1:0]        rnd;
    logic signed [MS_W-1:0] d;
    logic signed [MS_W-1:0] s;
    rnd = prod + MP_W'(HALF_LSB);
    d   = MS_W'($signed(rnd[MP_W-1:FRAC_DIR]));
    s   = MS_W'(p) + d;
    if (s[MS_W-1:POS_W-1] != {(MS_W - POS_W + 1){s[MS_W-1]}}) begin
      return s[MS_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return s[POS_W-1:0];
  endfunction

  // rotation component with round and saturation
  function automatic logic signed [DIR_W-1:0] rot_comp(
    input logic signed [RP_W-1:0] p,
    input logic signed [RP_W-1:0] q,
    input logic                   sub
  );
    logic signed [RS_W-1:0] s;
    logic signed [RR_W-1:0] r;
    s = sub ? (RS_W'(p) - RS_W'(q)) : (RS_W'(p) + RS_W'(q));
    s = s + RS_W'(HALF_LSB);
    r = s[RS_W-1:FRAC_DIR];
    if (r[RR_W-1:DIR_W-1] != {(RR_W - DIR_W + 1){r[RR_W-1]}}) begin
      return r[RR_W-1] ? {1'b1, {(DIR_W-1){1'b0}}} : {1'b0, {(DIR_W-1){1'b1}}};
    end
    return r[DIR_W-1:0];
  endfunction

  // heading reversal, most negative saturates
  function automatic logic signed [DIR_W-1:0] rev_comp(input logic signed [DIR_W-1:0] d);
    return (d == {1'b1, {(DIR_W-1){1'b0}}}) ? {1'b0, {(DIR_W-1){1'b1}}} : -d;
  endfunction

  // action decode for the head item
  assign cmd           = q_item.cmd;
  assign can_emit      = !out_valid || !out_stall;
  assign stk_full      = (stk_level >= STK_LW'(STACK_DEPTH));
  assign stk_empty     = (stk_level == '0);
  assign stk_level_dec = stk_level - STK_LW'(1);

  assign act_move0 = q_valid && (cmd.kind == K_MOVE) && !phase && can_emit;
  assign act_move1 = q_valid && (cmd.kind == K_MOVE) && phase && can_emit;
  assign act_rot0  = q_valid && (cmd.kind == K_ROT) && !phase;
  assign act_rot1  = q_valid && (cmd.kind == K_ROT) && phase;
  assign act_rev   = q_valid && (cmd.kind == K_REV);
  assign act_push  = q_valid && (cmd.kind == K_PUSH) && !stk_full;
  assign act_over  = q_valid && (cmd.kind == K_PUSH) && stk_full && can_emit;
  assign act_pop0  = q_valid && (cmd.kind == K_POP) && !phase && !stk_empty;
  assign act_under = q_valid && (cmd.kind == K_POP) && !phase && stk_empty && can_emit;
  assign act_pop1  = q_valid && (cmd.kind == K_POP) && phase;
  assign act_begin = q_valid && (cmd.kind == K_BEGIN);
  assign act_nop   = q_valid && (cmd.kind == K_NOP);

  assign q_pop = act_move1 || act_rot1 || act_rev || act_push || act_over || act_pop1
              || act_under || act_begin || act_nop;
  assign emit  = act_move0 || act_move1 || act_over || act_under;

  // rotation operand select
  always_comb begin
    unique case (cmd.axis)
      AX_Y: begin
        rot_a = tdir_z;
        rot_b = tdir_x;
        rot_c = rot_y_cos;
        rot_s = rot_y_sin;
      end
      AX_Z: begin
        rot_a = tdir_x;
        rot_b = tdir_y;
        rot_c = rot_z_cos;
        rot_s = rot_z_sin;
      end
      default: begin
        rot_a = tdir_y;
        rot_b = tdir_z;
        rot_c = rot_x_cos;
        rot_s = rot_x_sin;
      end
    endcase
  end

  assign c_ext = (TRIG_W + 1)'(rot_c);
  assign s_eff = cmd.neg ? -((TRIG_W + 1)'(rot_s)) : (TRIG_W + 1)'(rot_s);

  // product registers, first phase of a move or turn
  always_ff @(posedge clk) begin
    if (act_move0) begin
      mp_x <= MP_W'(tdir_x) * MP_W'($signed({1'b0, step_len}));
      mp_y <= MP_W'(tdir_y) * MP_W'($signed({1'b0, step_len}));
      mp_z <= MP_W'(tdir_z) * MP_W'($signed({1'b0, step_len}));
    end
    if (act_rot0) begin
      rp_ca <= c_ext * rot_a;
      rp_sb <= s_eff * rot_b;
      rp_sa <= s_eff * rot_a;
      rp_cb <= c_ext * rot_b;
    end
  end

  // second phase results
  assign nxt_x  = move_comp(tpos_x, mp_x);
  assign nxt_y  = move_comp(tpos_y, mp_y);
  assign nxt_z  = move_comp(tpos_z, mp_z);
  assign rot_na = rot_comp(rp_ca, rp_sb, 1'b1);
  assign rot_nb = rot_comp(rp_sa, rp_cb, 1'b0);

  // branch stack
  assign stk_wdata = {tpos_x, tpos_y, tpos_z, tdir_x, tdir_y, tdir_z};

  ltt_ram #(
    .WIDTH (STK_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (act_push),
    .waddr (stk_level[STK_AW-1:0]),
    .wdata (stk_wdata),
    .raddr (stk_level_dec[STK_AW-1:0]),
    .rdata (stk_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_len  <= STEP_RESET;
      rot_x_cos <= TRIG_ONE;
      rot_x_sin <= '0;
      rot_y_cos <= TRIG_ONE;
      rot_y_sin <= '0;
      rot_z_cos <= TRIG_ONE;
      rot_z_sin <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:  step_len  <= cfg_data[STEP_W-1:0];
        REG_X_COS: rot_x_cos <= cfg_data[TRIG_W-1:0];
        REG_X_SIN: rot_x_sin <= cfg_data[TRIG_W-1:0];
        REG_Y_COS: rot_y_cos <= cfg_data[TRIG_W-1:0];
        REG_Y_SIN: rot_y_sin <= cfg_data[TRIG_W-1:0];
        REG_Z_COS: rot_z_cos <= cfg_data[TRIG_W-1:0];
        REG_Z_SIN: rot_z_sin <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // turtle state and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      tpos_x    <= '0;
      tpos_y    <= '0;
      tpos_z    <= '0;
      tdir_x    <= TRIG_ONE;
      tdir_y    <= '0;
      tdir_z    <= '0;
      stk_level <= '0;
      phase     <= 1'b0;
    end else begin
      if (act_move0 || act_rot0 || act_pop0) begin
        phase <= 1'b1;
      end else if (act_move1 || act_rot1 || act_pop1) begin
        phase <= 1'b0;
      end

      if (act_move1) begin
        tpos_x <= nxt_x;
        tpos_y <= nxt_y;
        tpos_z <= nxt_z;
      end else if (act_pop1) begin
        {tpos_x, tpos_y, tpos_z, tdir_x, tdir_y, tdir_z} <= stk_rdata;
      end else if (act_begin) begin
        tpos_x <= q_item.sx;
        tpos_y <= q_item.sy;
        tpos_z <= q_item.sz;
        tdir_x <= q_item.dx;
        tdir_y <= q_item.dy;
        tdir_z <= q_item.dz;
      end else if (act_rev) begin
        tdir_x <= rev_comp(tdir_x);
        tdir_y <= rev_comp(tdir_y);
        tdir_z <= rev_comp(tdir_z);
      end else if (act_rot1) begin
        unique case (cmd.axis)
          AX_Y: begin
            tdir_z <= rot_na;
            tdir_x <= rot_nb;
          end
          AX_Z: begin
            tdir_x <= rot_na;
            tdir_y <= rot_nb;
          end
          default: begin
            tdir_y <= rot_na;
            tdir_z <= rot_nb;
          end
        endcase
      end

      if (act_push) begin
        stk_level <= stk_level + STK_LW'(1);
      end else if (act_pop0) begin
        stk_level <= stk_level_dec;
      end else if (act_begin) begin
        stk_level <= '0;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (act_move0) begin
      pos_x       <= tpos_x;
      pos_y       <= tpos_y;
      pos_z       <= tpos_z;
      pen_down    <= cmd.pen;
      last_of_run <= 1'b0;
      status      <= ST_POINT;
    end else if (act_move1) begin
      pos_x       <= nxt_x;
      pos_y       <= nxt_y;
      pos_z       <= nxt_z;
      pen_down    <= cmd.pen;
      last_of_run <= 1'b1;
      status      <= ST_POINT;
    end else if (act_over || act_under) begin
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      pen_down    <= 1'b0;
      last_of_run <= 1'b1;
      status      <= act_over ? ST_OVER : ST_UNDER;
    end
  end

`ifndef SYNTHESIS
  // stack level never passes the stack size
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stk_level <= STK_LW'(STACK_DEPTH))
    else $error("stack level beyond stack size");

  // second phase only for move, turn and pop with the item still at the head
  a_phase_kind: assert property (@(posedge clk) disable iff (rst)
    phase |-> (q_valid && (cmd.kind == K_MOVE || cmd.kind == K_ROT || cmd.kind == K_POP)))
    else $error("second cycle without a two-cycle command");

  // a pop read lowers the level by one
  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    act_pop0 |=> (phase && stk_level == $past(stk_level) - STK_LW'(1)))
    else $error("pop did not lower the stack level");

  // the start point of a move is followed by the second phase with a result held
  a_move_pair: assert property (@(posedge clk) disable iff (rst)
    act_move0 |=> (phase && out_valid))
    else $error("move start point not followed by end point cycle");
`endif

endmodule

// File: design/lsystem_turtle_interpreter_top.sv
// ----------------------------------------------------------------------------
// lsystem_turtle_interpreter_top: 3d l-system turtle
// F and f emit a start point and then an end point through the single output
// register; turns use the product registers, then round and saturate, a pop a
// registered read of the 32-entry stack ram; begin, reverse, push, stack errors
// and unused opcodes need no second phase. A two-item queue sits between the
// decode front and the execution back; the output register lets the back go on
// with items that emit nothing while a result waits, and a forward symbol holds
// the queue head until its end point is registered. The stack ram needs no
// clearing after reset: only entries below the stack level are read.
// ----------------------------------------------------------------------------
module lsystem_turtle_interpreter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ltt_pkg::OP_W-1:0]            opcode,
  input  logic signed [ltt_pkg::POS_W-1:0]    start_pos_x,
  input  logic signed [ltt_pkg::POS_W-1:0]    start_pos_y,
  input  logic signed [ltt_pkg::POS_W-1:0]    start_pos_z,
  input  logic signed [ltt_pkg::DIR_W-1:0]    start_dir_x,
  input  logic signed [ltt_pkg::DIR_W-1:0]    start_dir_y,
  input  logic signed [ltt_pkg::DIR_W-1:0]    start_dir_z,
  input  logic                                cfg_we,
  input  logic [ltt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ltt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ltt_pkg::POS_W-1:0]    pos_x,
  output logic signed [ltt_pkg::POS_W-1:0]    pos_y,
  output logic signed [ltt_pkg::POS_W-1:0]    pos_z,
  output logic                                pen_down,
  output logic                                last_of_run,
  output logic [ltt_pkg::STAT_W-1:0]          status
);
  import ltt_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // decode and queue
  ltt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .start_pos_x (start_pos_x),
    .start_pos_y (start_pos_y),
    .start_pos_z (start_pos_z),
    .start_dir_x (start_dir_x),
    .start_dir_y (start_dir_y),
    .start_dir_z (start_dir_z),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  // execution and results
  ltt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .pen_down    (pen_down),
    .last_of_run (last_of_run),
    .status      (status)
  );

endmodule

// File: tb/sv/tb_lsystem_turtle_interpreter_top.sv
// ----------------------------------------------------------------------------
// tb_lsystem_turtle_interpreter_top: self-checking bench for the 3d turtle
// Drives symbol items with random gaps and random output stalls, mirrors the
// turtle state (position, heading, branch stack, turn angles) in a tracker
// class and compares every emitted point field by field in order. Runs a
// directed opening, several angle and step settings including the extremes,
// a deep nesting pass that overflows and underflows the stack, and a burst
// against a long output hold-off.
// ----------------------------------------------------------------------------
module tb_lsystem_turtle_interpreter_top;
  import ltt_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_Z_SIN + CFG_IDX_W'(1);

  // one symbol item as offered to the block
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] sz;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dz;
  } symbol_t;

  // one emitted point
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    pen;
    logic                    last;
    logic [STAT_W-1:0]       stat;
  } point_t;

  // mirror of the turtle state and the points still owed by the block
  class turtle_tracker;
    logic [STEP_W-1:0]       step_len;
    logic signed [TRIG_W-1:0] cos_q[3];
    logic signed [TRIG_W-1:0] sin_q[3];
    logic signed [POS_W-1:0] pos[3];
    logic signed [DIR_W-1:0] dir[3];
    logic signed [POS_W-1:0] saved_pos[3*STACK_DEPTH];
    logic signed [DIR_W-1:0] saved_dir[3*STACK_DEPTH];
    int                      level;
    point_t                  pending_points[$];
    int                      errors;

    function new();
      step_len = STEP_RESET;
      for (int i = 0; i < 3; i++) begin
        cos_q[i] = TRIG_ONE;
        sin_q[i] = '0;
        pos[i]   = '0;
        dir[i]   = '0;
      end
      dir[0] = TRIG_ONE;
      level  = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_STEP:  step_len = val[STEP_W-1:0];
        REG_X_COS: cos_q[0] = val[TRIG_W-1:0];
        REG_X_SIN: sin_q[0] = val[TRIG_W-1:0];
        REG_Y_COS: cos_q[1] = val[TRIG_W-1:0];
        REG_Y_SIN: sin_q[1] = val[TRIG_W-1:0];
        REG_Z_COS: cos_q[2] = val[TRIG_W-1:0];
        REG_Z_SIN: sin_q[2] = val[TRIG_W-1:0];
        default: ;
      endcase
    endfunction

    // round a q2.14 product: add half an lsb, floor shift
    function longint round_q14(longint v);
      return (v + (longint'(1) << (FRAC_DIR - 1))) >>> FRAC_DIR;
    endfunction

    function logic signed [DIR_W-1:0] sat_dir(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[DIR_W-1:0];
    endfunction

    function logic signed [POS_W-1:0] sat_pos(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[POS_W-1:0];
    endfunction

    // a' = c*a - s*b, b' = s*a + c*b on heading components a and b
    function void turn(int a, int b, longint c, longint s);
      longint va;
      longint vb;
      va = dir[a];
      vb = dir[b];
      dir[a] = sat_dir(round_q14(c * va - s * vb));
      dir[b] = sat_dir(round_q14(s * va + c * vb));
    endfunction

    function void owe_point(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic signed [POS_W-1:0] z, logic pen, logic last,
                            logic [STAT_W-1:0] stat);
      point_t p;
      p.x    = x;
      p.y    = y;
      p.z    = z;
      p.pen  = pen;
      p.last = last;
      p.stat = stat;
      pending_points = {pending_points, p};
    endfunction

    // advance the mirror by one accepted item
    function void take_symbol(symbol_t s);
      logic signed [POS_W-1:0] next_pos[3];
      logic                    pen;
      case (s.op)
        OP_FWD_DRAW, OP_FWD_MOVE: begin
          pen = (s.op == OP_FWD_DRAW);
          for (int i = 0; i < 3; i++)
            next_pos[i] = sat_pos(longint'(pos[i]) +
                                  round_q14(longint'(dir[i]) * longint'(step_len)));
          owe_point(pos[0], pos[1], pos[2], pen, 1'b0, ST_POINT);
          owe_point(next_pos[0], next_pos[1], next_pos[2], pen, 1'b1, ST_POINT);
          for (int i = 0; i < 3; i++) pos[i] = next_pos[i];
        end
        OP_TURN_POS:  turn(1, 2, cos_q[0], sin_q[0]);
        OP_TURN_NEG:  turn(1, 2, cos_q[0], -longint'(sin_q[0]));
        OP_PITCH_POS: turn(2, 0, cos_q[1], sin_q[1]);
        OP_PITCH_NEG: turn(2, 0, cos_q[1], -longint'(sin_q[1]));
        OP_ROLL_POS:  turn(0, 1, cos_q[2], sin_q[2]);
        OP_ROLL_NEG:  turn(0, 1, cos_q[2], -longint'(sin_q[2]));
        OP_REVERSE: begin
          for (int i = 0; i < 3; i++) dir[i] = sat_dir(-longint'(dir[i]));
        end
        OP_PUSH: begin
          if (level >= STACK_DEPTH) begin
            owe_point('0, '0, '0, 1'b0, 1'b1, ST_OVER);
          end else begin
            for (int i = 0; i < 3; i++) begin
              saved_pos[level*3+i] = pos[i];
              saved_dir[level*3+i] = dir[i];
            end
            level++;
          end
        end
        OP_POP: begin
          if (level == 0) begin
            owe_point('0, '0, '0, 1'b0, 1'b1, ST_UNDER);
          end else begin
            level--;
            for (int i = 0; i < 3; i++) begin
              pos[i] = saved_pos[level*3+i];
              dir[i] = saved_dir[level*3+i];
            end
          end
        end
        OP_BEGIN: begin
          pos[0] = s.sx;
          pos[1] = s.sy;
          pos[2] = s.sz;
          dir[0] = s.dx;
          dir[1] = s.dy;
          dir[2] = s.dz;
          level  = 0;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [POS_W-1:0] want,
                                logic [POS_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, name, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    // compare one accepted point with the oldest one owed
    function void check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual x=%0d y=%0d z=%0d status=%0d",
                 $time, got.x, got.y, got.z, got.stat);
        errors++;
        return;
      end
      want = pending_points.pop_front();
      compare_field("pos_x", want.x, got.x);
      compare_field("pos_y", want.y, got.y);
      compare_field("pos_z", want.z, got.z);
      compare_field("pen_down", POS_W'(want.pen), POS_W'(got.pen));
      compare_field("last_of_run", POS_W'(want.last), POS_W'(got.last));
      compare_field("status", POS_W'(want.stat), POS_W'(got.stat));
    endfunction
  endclass

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         opcode      = '0;
  logic signed [POS_W-1:0] start_pos_x = '0;
  logic signed [POS_W-1:0] start_pos_y = '0;
  logic signed [POS_W-1:0] start_pos_z = '0;
  logic signed [DIR_W-1:0] start_dir_x = '0;
  logic signed [DIR_W-1:0] start_dir_y = '0;
  logic signed [DIR_W-1:0] start_dir_z = '0;
  logic                    cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    pen_down;
  logic                    last_of_run;
  logic [STAT_W-1:0]       status;

  turtle_tracker tracker;
  int            gap_max      = 19;
  int            stall_max    = 19;
  int            hold_off_len = 0;
  int            cycle_count  = 0;

  lsystem_turtle_interpreter_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .start_pos_x (start_pos_x),
    .start_pos_y (start_pos_y),
    .start_pos_z (start_pos_z),
    .start_dir_x (start_dir_x),
    .start_dir_y (start_dir_y),
    .start_dir_z (start_dir_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .pen_down    (pen_down),
    .last_of_run (last_of_run),
    .status      (status)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL lsystem_turtle_interpreter_top");
    $finish;
  end

  // random payload around a given opcode
  function automatic symbol_t make_symbol(logic [OP_W-1:0] op);
    symbol_t s;
    s.op = op;
    if ($urandom_range(0, 1) == 1) begin
      s.sx = $urandom;
      s.sy = $urandom;
      s.sz = $urandom;
      s.dx = DIR_W'($urandom);
      s.dy = DIR_W'($urandom);
      s.dz = DIR_W'($urandom);
    end else begin
      s.sx = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      s.sy = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      s.sz = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      s.dx = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
      s.dy = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
      s.dz = DIR_W'(int'($urandom_range(0, 32768)) - 16384);
    end
    return s;
  endfunction

  // weighted symbol mix, mostly moves and turns
  function automatic logic [OP_W-1:0] pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_FWD_DRAW;
    if (r < 40) return OP_FWD_MOVE;
    if (r < 64) return OP_TURN_POS + OP_W'($urandom_range(0, 5));
    if (r < 68) return OP_REVERSE;
    if (r < 78) return OP_PUSH;
    if (r < 87) return OP_POP;
    if (r < 93) return OP_BEGIN;
    return OP_BEGIN + OP_W'($urandom_range(1, 4));
  endfunction

  function automatic int rand_trig();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // offer one item after a random gap and wait for it to be taken
  task automatic send_symbol(symbol_t s);
    int gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= s.op;
    start_pos_x <= s.sx;
    start_pos_y <= s.sy;
    start_pos_z <= s.sz;
    start_dir_x <= s.dx;
    start_dir_y <= s.dy;
    start_dir_z <= s.dz;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_symbol(s);
  endtask

  // stop offering and let every owed point drain out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // load step length and all three turn angles
  task automatic program_turtle(logic [STEP_W-1:0] step_len, int xc, int xs,
                                int yc, int ys, int zc, int zs);
    write_reg(REG_STEP, CFG_DATA_W'(step_len));
    write_reg(REG_X_COS, CFG_DATA_W'(xc));
    write_reg(REG_X_SIN, CFG_DATA_W'(xs));
    write_reg(REG_Y_COS, CFG_DATA_W'(yc));
    write_reg(REG_Y_SIN, CFG_DATA_W'(ys));
    write_reg(REG_Z_COS, CFG_DATA_W'(zc));
    write_reg(REG_Z_SIN, CFG_DATA_W'(zs));
    cfg_we <= 1'b0;
  endtask

  // point sink with random stalls and an optional long hold-off
  initial begin
    int     wait_len;
    point_t got;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        wait_len     = hold_off_len;
        hold_off_len = 0;
      end else begin
        wait_len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, stall_max);
      end
      if (wait_len > 0) begin
        out_stall <= 1'b1;
        repeat (wait_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got.x    = pos_x;
      got.y    = pos_y;
      got.z    = pos_z;
      got.pen  = pen_down;
      got.last = last_of_run;
      got.stat = status;
      tracker.check_point(got);
    end
  end

  // stimulus
  initial begin
    symbol_t s;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: underflow, plain draw, saturation, reverse of min heading
    send_symbol(make_symbol(OP_POP));
    send_symbol(make_symbol(OP_FWD_DRAW));
    s = make_symbol(OP_BEGIN);
    s.sx = 32'sh7FFFFFFF;
    s.sy = 32'sh80000000;
    s.sz = '0;
    s.dx = 16'sh7FFF;
    s.dy = 16'sh8000;
    s.dz = 16'sh0001;
    send_symbol(s);
    send_symbol(make_symbol(OP_FWD_DRAW));
    send_symbol(make_symbol(OP_REVERSE));
    send_symbol(make_symbol(OP_FWD_MOVE));
    for (int k = 1; k <= 4; k++) send_symbol(make_symbol(OP_BEGIN + OP_W'(k)));
    send_symbol(make_symbol(OP_PUSH));
    send_symbol(make_symbol(OP_FWD_DRAW));
    send_symbol(make_symbol(OP_POP));
    send_symbol(make_symbol(OP_FWD_DRAW));

    // quarter, eighth and half turns: every rotation symbol
    wait_idle();
    program_turtle(31'd196608, 0, 16384, 11585, 11585, -16384, 0);
    s = make_symbol(OP_BEGIN);
    s.sx = '0;
    s.sy = '0;
    s.sz = '0;
    s.dx = 16'sd16384;
    s.dy = '0;
    s.dz = '0;
    send_symbol(s);
    send_symbol(make_symbol(OP_TURN_POS));
    send_symbol(make_symbol(OP_FWD_DRAW));
    send_symbol(make_symbol(OP_TURN_NEG));
    send_symbol(make_symbol(OP_PITCH_POS));
    send_symbol(make_symbol(OP_FWD_DRAW));
    send_symbol(make_symbol(OP_PITCH_NEG));
    send_symbol(make_symbol(OP_ROLL_POS));
    send_symbol(make_symbol(OP_FWD_MOVE));
    send_symbol(make_symbol(OP_ROLL_NEG));
    send_symbol(make_symbol(OP_FWD_DRAW));

    // random mixes under several settings, extremes included
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          program_turtle(STEP_W'($urandom_range(0, 1 << 18)), rand_trig(), rand_trig(),
                         rand_trig(), rand_trig(), rand_trig(), rand_trig());
          gap_max   = 19;
          stall_max = 19;
        end
        1: begin
          program_turtle('0, -16384, 16384, -16384, 16384, -16384, 16384);
          gap_max   = 0;
          stall_max = 0;
        end
        2: begin
          write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
          program_turtle('1, 16384, -16384, 16384, -16384, 16384, -16384);
          gap_max   = 3;
          stall_max = 19;
        end
        default: begin
          program_turtle(STEP_W'($urandom), rand_trig(), rand_trig(),
                         rand_trig(), rand_trig(), rand_trig(), rand_trig());
          gap_max   = 19;
          stall_max = 3;
        end
      endcase
      repeat (60) send_symbol(make_symbol(pick_opcode()));
    end

    // nest past the stack depth, then unwind past empty
    wait_idle();
    program_turtle(STEP_W'($urandom_range(0, 1 << 17)), rand_trig(), rand_trig(),
                   rand_trig(), rand_trig(), rand_trig(), rand_trig());
    gap_max   = 3;
    stall_max = 3;
    send_symbol(make_symbol(OP_BEGIN));
    repeat (STACK_DEPTH + 2) begin
      send_symbol(make_symbol(OP_PUSH));
      send_symbol(make_symbol(OP_FWD_DRAW + OP_W'($urandom_range(0, 7))));
    end
    repeat (STACK_DEPTH + 4) begin
      send_symbol(make_symbol(OP_POP));
      send_symbol(make_symbol(OP_FWD_DRAW));
    end

    // back-to-back draws against a long output hold-off
    wait_idle();
    gap_max      = 0;
    stall_max    = 19;
    hold_off_len = 200;
    repeat (40) send_symbol(make_symbol(OP_FWD_DRAW));

    wait_idle();
    if (tracker.errors == 0)
      $display("PASS lsystem_turtle_interpreter_top");
    else
      $display("FAIL lsystem_turtle_interpreter_top");
    $finish;
  end

endmodule

// File: filelist.f
design/ltt_pkg.sv
design/ltt_ram.sv
design/ltt_front.sv
design/ltt_back.sv
design/lsystem_turtle_interpreter_top.sv
tb/sv/tb_lsystem_turtle_interpreter_top.sv
